/* rtl/esdb_pkg.sv */
// ----------------------------------------------------------------------------
// esdb_pkg
// Shared widths, command codes and control types for the echo scatter
// delay buffer.
// ----------------------------------------------------------------------------
package esdb_pkg;

  localparam int DEPTH_DEF       = 65536;
  localparam int MAX_REPEATS_DEF = 63;

  localparam int SAMPLE_W  = 24;
  localparam int DWHOLE_W  = 17;
  localparam int FRAC_W    = 8;
  localparam int COUNT_W   = 6;
  localparam int SPACING_W = 16;
  localparam int GAIN_W    = 16;
  localparam int CMD_W     = 2;

  // input word: sample, delay_whole, delay_fraction, repeat_count,
  // repeat_spacing, echo_gain, zero pad to whole bytes
  localparam int IN_BITS = SAMPLE_W + DWHOLE_W + FRAC_W + COUNT_W + SPACING_W + GAIN_W;
  localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_W   = SAMPLE_W;

  // running delay: delay_whole plus up to 63 spacings
  localparam int DLY_W    = 23;
  localparam int ACC_W    = 32;
  localparam int ADDEND_W = SAMPLE_W + 1;
  localparam int MULB_W   = GAIN_W + 1;
  localparam int PROD_W   = SAMPLE_W + MULB_W;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INTERP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  typedef struct packed {
    logic wr_en;    // write the slot at the shared address
    logic wr_zero;  // write zero instead of the accumulated sum
  } slot_ctrl_t;

endpackage

/* rtl/echo_scatter_delay_buffer_unit.sv */
// ----------------------------------------------------------------------------
// echo_scatter_delay_buffer_unit
// Circular store of 32-bit accumulators with echo scatter, fractional
// split and read-and-clear tick, run by a small sequencer.
// ----------------------------------------------------------------------------
// After reset the block clears its store, one slot a cycle, before it takes
// the first word. It handles one word at a time through one read-modify-write
// port and one shared multiplier. An add word runs a read and a write state
// per copy (the next echo level is multiplied during the read) and a last
// read; an interpolated add runs a multiply and a split state, then a read and
// a write per slot; a tick reads, then holds its write state until the output
// register is free. The next word is taken once the sequencer is back to
// idle; a finished tick result may still sit in the output register then.
// ----------------------------------------------------------------------------
module echo_scatter_delay_buffer_unit #(
  parameter int DEPTH       = esdb_pkg::DEPTH_DEF,
  parameter int MAX_REPEATS = esdb_pkg::MAX_REPEATS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // sample_in, delay_whole, delay_fraction, repeat_count, repeat_spacing,
  // echo_gain, zero pad
  input  logic [esdb_pkg::IN_W-1:0]     s_axis_tdata,
  // command
  input  logic [esdb_pkg::CMD_W-1:0]    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // sample_out
  output logic [esdb_pkg::OUT_W-1:0]    m_axis_tdata
);
  import esdb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW:0]      DEPTH_A  = (AW+1)'(DEPTH);
  localparam logic [AW-1:0]    LAST_A   = AW'(DEPTH - 1);
  localparam logic [DLY_W-1:0] DEPTH_D  = DLY_W'(DEPTH);
  localparam logic signed [ACC_W-1:0] OMAX = ACC_W'((2 ** (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] OMIN = -ACC_W'(2 ** (SAMPLE_W - 1));

  localparam int P_DW = SAMPLE_W;
  localparam int P_FR = P_DW + DWHOLE_W;
  localparam int P_CN = P_FR + FRAC_W;
  localparam int P_SP = P_CN + COUNT_W;
  localparam int P_GN = P_SP + SPACING_W;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CLEAR = 8'b0000_0010,
    ST_MUL   = 8'b0000_0100,
    ST_LO    = 8'b0000_1000,
    ST_RD    = 8'b0001_0000,
    ST_WR    = 8'b0010_0000,
    ST_TRD   = 8'b0100_0000,
    ST_TWR   = 8'b1000_0000
  } state_t;

  state_t state;

  logic signed [SAMPLE_W-1:0] s;
  logic signed [MULB_W-1:0]   mb;
  logic [DLY_W-1:0]           dly;
  logic [COUNT_W-1:0]         cnt;
  logic [SPACING_W-1:0]       spacing;
  logic signed [ADDEND_W-1:0] addend;
  logic signed [SAMPLE_W-1:0] upper;
  logic                       interp;
  logic                       half;
  logic [AW-1:0]              rp;
  logic [AW-1:0]              clr_addr;
  logic                       out_valid;
  logic [OUT_W-1:0]           out_data;

  logic                       accept;
  logic                       out_free;
  logic                       dly_out;
  logic [AW:0]                sum_a;
  logic [AW:0]                wrap_a;
  logic [AW-1:0]              addr;
  logic [AW-1:0]              rp_inc;
  logic signed [SAMPLE_W-1:0] scaled;
  logic signed [ACC_W-1:0]    rdata;
  logic [OUT_W-1:0]           rd_clamp;
  logic [COUNT_W-1:0]         cnt_in;
  logic                       scale_en;
  slot_ctrl_t                 ctrl;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign out_free      = !out_valid || m_axis_tready;

  assign dly_out = (dly >= DEPTH_D);
  assign sum_a   = {1'b0, rp} + {1'b0, dly[AW-1:0]};
  assign wrap_a  = (sum_a >= DEPTH_A) ? (sum_a - DEPTH_A) : sum_a;
  assign rp_inc  = (rp == LAST_A) ? '0 : (rp + AW'(1));
  assign cnt_in  = (32'(s_axis_tdata[P_SP-1:P_CN]) > MAX_REPEATS)
                 ? COUNT_W'(MAX_REPEATS) : s_axis_tdata[P_SP-1:P_CN];

  always_comb begin
    case (state)
      ST_CLEAR:       addr = clr_addr;
      ST_TRD, ST_TWR: addr = rp;
      default:        addr = wrap_a[AW-1:0];
    endcase
  end

  always_comb begin
    ctrl.wr_en   = (state == ST_CLEAR) || (state == ST_WR)
                || ((state == ST_TWR) && out_free);
    ctrl.wr_zero = (state == ST_CLEAR) || (state == ST_TWR);
  end

  assign scale_en = (state == ST_MUL) || (state == ST_RD);

  always_comb begin
    if (rdata > OMAX) begin
      rd_clamp = OMAX[OUT_W-1:0];
    end else if (rdata < OMIN) begin
      rd_clamp = OMIN[OUT_W-1:0];
    end else begin
      rd_clamp = rdata[OUT_W-1:0];
    end
  end

  esdb_scale u_scale (
    .clk    (clk),
    .en     (scale_en),
    .interp (interp),
    .a      (s),
    .b      (mb),
    .result (scaled)
  );

  esdb_slots #(
    .DEPTH (DEPTH)
  ) u_slots (
    .clk    (clk),
    .ctrl   (ctrl),
    .addr   (addr),
    .addend (addend),
    .rdata  (rdata)
  );

  // a new tick result may load while the previous word leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_TWR) && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      rp        <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_A) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            s       <= s_axis_tdata[P_DW-1:0];
            dly     <= DLY_W'(s_axis_tdata[P_FR-1:P_DW]);
            cnt     <= cnt_in;
            spacing <= s_axis_tdata[P_GN-1:P_SP];
            interp  <= (s_axis_tuser == CMD_INTERP);
            half    <= 1'b0;
            if (s_axis_tuser == CMD_INTERP) begin
              mb <= {{(MULB_W - FRAC_W){1'b0}}, s_axis_tdata[P_CN-1:P_FR]};
            end else begin
              mb <= {s_axis_tdata[P_GN+GAIN_W-1], s_axis_tdata[P_GN+GAIN_W-1:P_GN]};
            end
            case (s_axis_tuser)
              CMD_ADD:    state <= ST_RD;
              CMD_INTERP: state <= ST_MUL;
              CMD_TICK:   state <= ST_TRD;
              default:    state <= ST_IDLE;
            endcase
          end
        end
        ST_MUL: begin
          state <= ST_LO;
        end
        ST_LO: begin
          // split: upper slot gets the rounded share, lower the remainder
          upper  <= scaled;
          addend <= {s[SAMPLE_W-1], s} - {scaled[SAMPLE_W-1], scaled};
          state  <= ST_RD;
        end
        ST_RD: begin
          // delay only grows, so the first out-of-range write ends the word
          if (dly_out || (!interp && (cnt == '0))) begin
            state <= ST_IDLE;
          end else begin
            if (!interp) begin
              addend <= {s[SAMPLE_W-1], s};
            end
            state <= ST_WR;
          end
        end
        ST_WR: begin
          if (interp) begin
            if (half) begin
              state <= ST_IDLE;
            end else begin
              dly    <= dly + DLY_W'(1);
              addend <= {upper[SAMPLE_W-1], upper};
              half   <= 1'b1;
              state  <= ST_RD;
            end
          end else begin
            s     <= scaled;
            dly   <= dly + DLY_W'(spacing);
            cnt   <= cnt - COUNT_W'(1);
            state <= ST_RD;
          end
        end
        ST_TRD: begin
          state <= ST_TWR;
        end
        ST_TWR: begin
          if (out_free) begin
            out_data  <= rd_clamp;
            rp        <= rp_inc;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/esdb_scale.sv */
// ----------------------------------------------------------------------------
// esdb_scale
// Shared multiplier: registered product, then round-half-up shift and
// clamp to the sample range. Shift is 15 for echo gain, 8 for fraction split.
// ----------------------------------------------------------------------------
module esdb_scale (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic                                  interp,
  input  logic signed [esdb_pkg::SAMPLE_W-1:0]  a,
  input  logic signed [esdb_pkg::MULB_W-1:0]    b,
  output logic signed [esdb_pkg::SAMPLE_W-1:0]  result
);
  import esdb_pkg::*;

  localparam logic signed [PROD_W-1:0] SMAX  = PROD_W'((2 ** (SAMPLE_W - 1)) - 1);
  localparam logic signed [PROD_W-1:0] SMIN  = -PROD_W'(2 ** (SAMPLE_W - 1));
  localparam logic signed [PROD_W-1:0] HALF8  = PROD_W'(128);
  localparam logic signed [PROD_W-1:0] HALF15 = PROD_W'(16384);

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rounded;
  logic signed [PROD_W-1:0] shifted;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(a) * PROD_W'(b);
    end
  end

  always_comb begin
    rounded = prod + (interp ? HALF8 : HALF15);
    shifted = interp ? (rounded >>> 8) : (rounded >>> 15);
    if (shifted > SMAX) begin
      result = SMAX[SAMPLE_W-1:0];
    end else if (shifted < SMIN) begin
      result = SMIN[SAMPLE_W-1:0];
    end else begin
      result = shifted[SAMPLE_W-1:0];
    end
  end

endmodule

/* rtl/esdb_slots.sv */
// ----------------------------------------------------------------------------
// esdb_slots
// Slot store: one port read every cycle into a register, one write of
// either zero or the saturated sum of the read value and an addend.
// ----------------------------------------------------------------------------
module esdb_slots #(
  parameter int DEPTH = esdb_pkg::DEPTH_DEF
) (
  input  logic                                  clk,
  input  esdb_pkg::slot_ctrl_t                  ctrl,
  input  logic [$clog2(DEPTH)-1:0]              addr,
  input  logic signed [esdb_pkg::ADDEND_W-1:0]  addend,
  output logic signed [esdb_pkg::ACC_W-1:0]     rdata
);
  import esdb_pkg::*;

  localparam logic signed [ACC_W:0] AMAX = (ACC_W+1)'((64'd1 << (ACC_W - 1)) - 64'd1);
  localparam logic signed [ACC_W:0] AMIN = -(ACC_W+1)'(64'd1 << (ACC_W - 1));

  logic [ACC_W-1:0] mem [DEPTH];
  logic signed [ACC_W:0] sum;
  logic signed [ACC_W-1:0] wdata;

  always_comb begin
    sum = {rdata[ACC_W-1], rdata}
        + {{(ACC_W + 1 - ADDEND_W){addend[ADDEND_W-1]}}, addend};
    if (ctrl.wr_zero) begin
      wdata = '0;
    end else if (sum > AMAX) begin
      wdata = AMAX[ACC_W-1:0];
    end else if (sum < AMIN) begin
      wdata = AMIN[ACC_W-1:0];
    end else begin
      wdata = sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* verif/echo_scatter_delay_buffer_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_scatter_delay_buffer_unit_tb
// Drives add, interpolated add, tick and unused command words into the echo
// scatter delay buffer and checks every tick output against a slot store
// kept in the bench. A directed part covers extremes and skip cases, then
// four random phases run with and without sender idling and sink stalls.
// ----------------------------------------------------------------------------
module echo_scatter_delay_buffer_unit_tb;

  import esdb_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int MAX_REPEATS = MAX_REPEATS_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam longint ACC_MAX    = 64'sd2147483647;
  localparam longint ACC_MIN    = -64'sd2147483648;
  localparam longint SAMPLE_MAX = 64'sd8388607;
  localparam longint SAMPLE_MIN = -64'sd8388608;

  // input word layout, low bits last in the member list
  typedef struct packed {
    logic               pad;
    logic signed [15:0] gain;
    logic [15:0]        spacing;
    logic [5:0]         count;
    logic [7:0]         frac;
    logic [16:0]        dwhole;
    logic signed [23:0] sample;
  } esdb_word_t;

  class slot_scoreboard;
    int          slot_acc [DEPTH];
    int unsigned rd_pos;
    logic [OUT_W-1:0] pending_samples [$];
    int err_count;
    int n_add, n_interp, n_tick, n_ignored, n_checked;

    function longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void add_to_slot(longint dly, longint val);
      int unsigned idx;
      longint sum;
      if (dly >= DEPTH) return;
      idx = int'((longint'(rd_pos) + dly) % DEPTH);
      sum = longint'(slot_acc[idx]) + val;
      slot_acc[idx] = int'(clamp(sum, ACC_MIN, ACC_MAX));
    endfunction

    function void apply_word(logic [CMD_W-1:0] cmd, logic [IN_W-1:0] data);
      esdb_word_t w;
      longint s, g, dly, upper, v;
      int cnt;
      w   = data;
      s   = longint'(w.sample);
      g   = longint'(w.gain);
      dly = longint'(w.dwhole);
      case (cmd)
        CMD_ADD: begin
          n_add++;
          cnt = int'(w.count);
          if (cnt > MAX_REPEATS) cnt = MAX_REPEATS;
          for (int i = 0; i < cnt; i++) begin
            add_to_slot(dly, s);
            // Q1.15 scale, round half up
            s = clamp((s * g + 16384) >>> 15, SAMPLE_MIN, SAMPLE_MAX);
            dly += longint'(w.spacing);
          end
        end
        CMD_INTERP: begin
          n_interp++;
          if (dly < DEPTH) begin
            upper = (s * longint'(w.frac) + 128) >>> 8;
            add_to_slot(dly, s - upper);
            add_to_slot(dly + 1, upper);
          end
        end
        CMD_TICK: begin
          n_tick++;
          v = clamp(longint'(slot_acc[rd_pos]), SAMPLE_MIN, SAMPLE_MAX);
          slot_acc[rd_pos] = 0;
          rd_pos = (rd_pos + 1) % DEPTH;
          pending_samples.push_back(v[OUT_W-1:0]);
        end
        default: n_ignored++;
      endcase
    endfunction

    function void check_out_sample(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] exp_s;
      if (pending_samples.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("[%0t] unexpected output word %h", $realtime, got);
        return;
      end
      exp_s = pending_samples.pop_front();
      n_checked++;
      if (got !== exp_s) begin
        err_count++;
        if (err_count <= 10)
          $display("[%0t] sample_out mismatch: expected %h, got %h", $realtime, exp_s, got);
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic [CMD_W-1:0] s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;

  int sender_idle_pct = 0;
  int sink_stall_pct  = 0;

  slot_scoreboard sb = new();

  echo_scatter_delay_buffer_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    m_axis_tready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_out_sample(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.apply_word(s_axis_tuser, s_axis_tdata);
    end
  end

  function automatic esdb_word_t make_word(int sample, int dwhole, int frac, int count,
                                           int spacing, int gain);
    esdb_word_t w;
    w         = '0;
    w.sample  = 24'(sample);
    w.dwhole  = 17'(dwhole);
    w.frac    = 8'(frac);
    w.count   = 6'(count);
    w.spacing = 16'(spacing);
    w.gain    = 16'(gain);
    return w;
  endfunction

  // small delays most of the time so writes land in slots that ticks reach soon
  function automatic esdb_word_t rand_word();
    esdb_word_t w;
    int r;
    w = '0;
    r = $urandom_range(9);
    if (r == 0)      w.sample = 24'h7FFFFF;
    else if (r == 1) w.sample = 24'h800000;
    else             w.sample = 24'($urandom());
    r = $urandom_range(9);
    if (r < 8)       w.dwhole = 17'($urandom_range(0, 24));
    else if (r == 8) w.dwhole = 17'($urandom_range(DEPTH - 8, DEPTH + 4));
    else             w.dwhole = 17'($urandom());
    w.frac = 8'($urandom());
    r = $urandom_range(9);
    if (r < 7)       w.count = 6'($urandom_range(0, 6));
    else             w.count = 6'($urandom_range(0, 63));
    if ($urandom_range(9) < 7) w.spacing = 16'($urandom_range(0, 6));
    else                       w.spacing = 16'($urandom());
    w.gain = 16'($urandom());
    return w;
  endfunction

  // called and returns at a falling edge
  task automatic send_word(input logic [CMD_W-1:0] cmd, input esdb_word_t w);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic send_tick();
    send_word(CMD_TICK, make_word(0, 0, 0, 0, 0, 0));
  endtask

  task automatic drain_outputs();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_samples.size() != 0) @(negedge clk);
  endtask

  initial begin
    int r;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_TICK;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, echo saturation, skipped writes
    send_tick();
    send_word(CMD_ADD, make_word(8388607, 0, 0, 1, 0, 0));
    send_tick();
    send_word(CMD_ADD, make_word(-8388608, 2, 0, 3, 1, -32768));
    send_word(CMD_INTERP, make_word(8388607, 0, 255, 0, 0, 0));
    send_word(CMD_INTERP, make_word(-8388608, 1, 128, 0, 0, 0));
    send_word(CMD_INTERP, make_word(12345, DEPTH - 1, 200, 0, 0, 0));
    send_word(CMD_INTERP, make_word(-1, DEPTH, 1, 0, 0, 0));
    send_word(CMD_ADD, make_word(777, 131071, 0, 5, 0, 32767));
    send_word(CMD_ADD, make_word(4242, 0, 0, 0, 0, 32767));
    send_word(CMD_ADD, make_word(-5000, DEPTH - 6, 0, 4, 3, 16384));
    send_word(CMD_UNUSED, rand_word());
    repeat (3) send_tick();
    // drive one slot past the 32-bit limit and then back down
    repeat (5) send_word(CMD_ADD, make_word(8388607, 1, 0, 63, 0, 32767));
    repeat (5) send_word(CMD_ADD, make_word(-8388608, 1, 0, 63, 0, 32767));
    repeat (2) send_tick();
    drain_outputs();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin sender_idle_pct = 72; sink_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  sink_stall_pct = 72; end
        default: begin sender_idle_pct = 32; sink_stall_pct = 32; end
      endcase
      for (int n = 0; n < 112; n++) begin
        r = $urandom_range(99);
        if (r < 36)      send_tick();
        else if (r < 68) send_word(CMD_ADD, rand_word());
        else if (r < 95) send_word(CMD_INTERP, rand_word());
        else             send_word(CMD_UNUSED, rand_word());
      end
      // sender holds off until every pending tick output has come back
      drain_outputs();
    end

    repeat (200) @(negedge clk);
    if (sb.pending_samples.size() != 0)
      $display("%0d tick outputs never arrived", sb.pending_samples.size());
    $display("covered %0d add, %0d interpolated add, %0d tick and %0d unused words",
             sb.n_add, sb.n_interp, sb.n_tick, sb.n_ignored);
    $display("%0d output words compared, %0d errors", sb.n_checked, sb.err_count);
    if (sb.err_count == 0 && sb.pending_samples.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout waiting on the block");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/esdb_pkg.sv
rtl/esdb_scale.sv
rtl/esdb_slots.sv
rtl/echo_scatter_delay_buffer_unit.sv
verif/echo_scatter_delay_buffer_unit_tb.sv
